@@ hw/rtl/xhtc_pkg.sv @@
// ----------------------------------------------------------------------------
// xhtc_pkg
// Shared types, register indexes, status codes and character helpers of the
// repeating-key xor hex token codec.
// ----------------------------------------------------------------------------
package xhtc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 3'd5;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam logic [5:0] KEY_LEN_RESET = 6'd30;
  localparam int         KEY_SLOTS     = 32;
  localparam int         KEY_POS_W     = 5;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
  localparam logic [1:0] ST_BAD_HEX    = 2'd2;
  localparam logic [1:0] ST_ODD_COUNT  = 2'd3;

  // prefix position 3 means the whole prefix has been seen or sent
  localparam logic [1:0] PREFIX_DONE = 2'd3;

  // result steps of an encrypt word: three prefix characters, then two digits
  localparam logic [2:0] ENC_HI_STEP   = 3'd3;
  localparam logic [2:0] ENC_LAST_STEP = 3'd4;

  typedef enum logic [1:0] {
    JOB_ENC,
    JOB_DATA,
    JOB_STATUS
  } job_kind_t;

  // one unit of work handed from the front end to the back end
  typedef struct packed {
    job_kind_t  kind;
    logic       with_prefix;
    logic [7:0] value;
    logic       last;
    logic [1:0] status;
  } job_t;

  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = 8'h78;  // x
      2'd1:    ch = 8'h31;  // 1
      2'd2:    ch = 8'h3A;  // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] nibble_to_hex(input logic [3:0] n);
    logic [7:0] ch;
    if (n < 4'd10) begin
      ch = 8'h30 + {4'h0, n};
    end else begin
      ch = 8'h57 + {4'h0, n};
    end
    return ch;
  endfunction

  // returns {ok, nibble}; either case of letter digits
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/xhtc_in_if.sv @@
// ----------------------------------------------------------------------------
// xhtc_in_if
// Input channel: one message byte or character per word.
// ----------------------------------------------------------------------------
interface xhtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ hw/rtl/xhtc_out_if.sv @@
// ----------------------------------------------------------------------------
// xhtc_out_if
// Result channel: one character, plaintext byte or status per word.
// ----------------------------------------------------------------------------
interface xhtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                  input status, output ready);
endinterface

@@ hw/rtl/xor_hex_token_codec.sv @@
// ----------------------------------------------------------------------------
// xor_hex_token_codec
// Repeating-key xor codec with prefixed hex text, one message byte per word.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    in_byte[7:0], in_last
//   out_ch   out  valid/ready    out_byte[7:0], byte_valid, out_last, status[1:0]
//   cfg_*    in   cfg_we only    cfg_index[2:0], cfg_data[63:0]
//
// The front end takes one word per cycle while the job queue has room.
// The back end emits one result per cycle while out_ch is not stalled: an
// encrypt byte gives two hex digits, after the three prefix characters for
// the first byte of a message; a decrypt word gives at most one result.
// Decrypt takes one character per cycle while the job queue has room.
// Reset is synchronous; no clearing pass. Either side may stall freely.
// ----------------------------------------------------------------------------
module xor_hex_token_codec #(
  parameter int KEY_MAX_BYTES = 32,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [xhtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xhtc_pkg::CFG_DATA_W-1:0] cfg_data,
  xhtc_in_if.sink                         in_ch,
  xhtc_out_if.source                      out_ch
);

  import xhtc_pkg::*;

  localparam int JOB_W = $bits(job_t);

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  job_t             q_job;
  job_t             q_head;
  logic [JOB_W-1:0] q_head_bits;

  assign q_head = job_t'(q_head_bits);

  xhtc_front #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  xhtc_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_job),
    .pop       (q_pop),
    .head      (q_head_bits),
    .empty     (q_empty),
    .full      (q_full)
  );

  xhtc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ hw/rtl/xhtc_queue.sv @@
// ----------------------------------------------------------------------------
// xhtc_queue
// Small flop-based fifo that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module xhtc_queue #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_FULL);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_FULL)
    else $error("queue count out of range");

endmodule

@@ hw/rtl/xhtc_front.sv @@
// ----------------------------------------------------------------------------
// xhtc_front
// Configuration registers and message state; takes one word a cycle while the
// queue has room; checks prefix and hex digits, applies the key, queues jobs.
// ----------------------------------------------------------------------------
module xhtc_front #(
  parameter int KEY_MAX_BYTES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [xhtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xhtc_pkg::CFG_DATA_W-1:0] cfg_data,
  xhtc_in_if.sink                         in_ch,
  input  logic                            q_full,
  output logic                            q_push,
  output xhtc_pkg::job_t                  q_job
);

  import xhtc_pkg::*;

  localparam logic [5:0] KEY_MAX = 6'(KEY_MAX_BYTES);

  logic                  mode_r;
  logic [5:0]            key_len_r;
  logic [63:0]           key_word_r [4];
  logic [KEY_POS_W-1:0]  key_pos_r, key_pos_nxt;
  logic [1:0]            prefix_r, prefix_nxt;
  logic                  phase_r, phase_nxt;
  logic [3:0]            held_r, held_nxt;
  logic [1:0]            fail_r, fail_nxt;

  logic                  accept;
  logic [255:0]          key_flat;
  logic [7:0]            key_byte;
  logic [5:0]            eff_len;
  logic [5:0]            pos_inc;
  logic [KEY_POS_W-1:0]  pos_adv;
  logic [4:0]            hex;
  logic [1:0]            end_code;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign key_flat = {key_word_r[3], key_word_r[2], key_word_r[1], key_word_r[0]};
  assign key_byte = key_flat[{key_pos_r, 3'b000} +: 8];

  always_comb begin
    if (key_len_r == 6'd0) begin
      eff_len = 6'd1;
    end else if (key_len_r > KEY_MAX) begin
      eff_len = KEY_MAX;
    end else begin
      eff_len = key_len_r;
    end
  end

  assign pos_inc = {1'b0, key_pos_r} + 6'd1;
  assign pos_adv = (pos_inc >= eff_len) ? '0 : pos_inc[KEY_POS_W-1:0];
  assign hex     = hex_decode(in_ch.in_byte);

  always_comb begin
    key_pos_nxt = key_pos_r;
    prefix_nxt  = prefix_r;
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    fail_nxt    = fail_r;
    q_push      = 1'b0;
    q_job       = '{kind: JOB_ENC, with_prefix: 1'b0, value: 8'h00, last: in_ch.in_last,
                    status: ST_OK};
    end_code    = ST_OK;

    if (accept) begin
      if (mode_r == MODE_ENCRYPT) begin
        q_push            = 1'b1;
        q_job.kind        = JOB_ENC;
        q_job.with_prefix = (prefix_r == 2'd0);
        q_job.value       = in_ch.in_byte ^ key_byte;
        key_pos_nxt       = pos_adv;
        // a partly checked decrypt prefix is left where it stands
        if (prefix_r == 2'd0) begin
          prefix_nxt = PREFIX_DONE;
        end
      end else begin
        if (fail_r == ST_OK) begin
          if (prefix_r != PREFIX_DONE) begin
            if (in_ch.in_byte == prefix_char(prefix_r)) begin
              prefix_nxt = prefix_r + 2'd1;
            end else begin
              fail_nxt = ST_BAD_PREFIX;
            end
          end else if (!hex[4]) begin
            fail_nxt = ST_BAD_HEX;
          end else if (!phase_r) begin
            held_nxt  = hex[3:0];
            phase_nxt = 1'b1;
          end else begin
            q_push      = 1'b1;
            q_job.kind  = JOB_DATA;
            q_job.value = {held_r, hex[3:0]} ^ key_byte;
            key_pos_nxt = pos_adv;
            phase_nxt   = 1'b0;
            held_nxt    = 4'h0;
          end
        end
        // end of message with no data word: a status-only result
        if (in_ch.in_last && !q_push) begin
          end_code = fail_nxt;
          if (end_code == ST_OK && prefix_nxt != PREFIX_DONE) begin
            end_code = ST_BAD_PREFIX;
          end else if (end_code == ST_OK && phase_nxt) begin
            end_code = ST_ODD_COUNT;
          end
          q_push       = 1'b1;
          q_job.kind   = JOB_STATUS;
          q_job.status = end_code;
        end
      end
      if (in_ch.in_last) begin
        key_pos_nxt = '0;
        prefix_nxt  = 2'd0;
        phase_nxt   = 1'b0;
        held_nxt    = 4'h0;
        fail_nxt    = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_ENCRYPT;
      key_len_r     <= KEY_LEN_RESET;
      key_word_r[0] <= '0;
      key_word_r[1] <= '0;
      key_word_r[2] <= '0;
      key_word_r[3] <= '0;
      key_pos_r     <= '0;
      prefix_r      <= 2'd0;
      phase_r       <= 1'b0;
      held_r        <= 4'h0;
      fail_r        <= ST_OK;
    end else begin
      key_pos_r <= key_pos_nxt;
      prefix_r  <= prefix_nxt;
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      fail_r    <= fail_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:      mode_r        <= cfg_data[0];
          CFG_KEY_LEN:   key_len_r     <= cfg_data[5:0];
          CFG_KEY_WORD0: key_word_r[0] <= cfg_data;
          CFG_KEY_WORD1: key_word_r[1] <= cfg_data;
          CFG_KEY_WORD2: key_word_r[2] <= cfg_data;
          CFG_KEY_WORD3: key_word_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  a_msg_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.in_last) |=> (key_pos_r == '0 && prefix_r == 2'd0 && !phase_r
                                   && fail_r == ST_OK))
    else $error("message state not cleared at end of message");
  a_last_always_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.in_last) |-> q_push)
    else $error("end of message produced no job");
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> accept)
    else $error("job queued without an accepted word");

endmodule

@@ hw/rtl/xhtc_back.sv @@
// ----------------------------------------------------------------------------
// xhtc_back
// Expands queued jobs into result words, one a cycle while the output is not
// stalled, through an output register.
// ----------------------------------------------------------------------------
module xhtc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  xhtc_pkg::job_t q_head,
  input  logic           q_empty,
  output logic           q_pop,
  xhtc_out_if.source     out_ch
);

  import xhtc_pkg::*;

  logic       out_valid_r;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       byte_valid_r, byte_valid_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] status_r, status_nxt;
  logic [2:0] step_r, step_nxt;
  logic [2:0] eff_step;
  logic       done;
  logic       load;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.byte_valid = byte_valid_r;
  assign out_ch.out_last   = out_last_r;
  assign out_ch.status     = status_r;

  assign load  = !q_empty && (!out_valid_r || out_ch.ready);
  assign q_pop = load && done;

  // without the prefix an encrypt job starts at its high digit
  assign eff_step = (q_head.kind == JOB_ENC && !q_head.with_prefix) ?
                    step_r + ENC_HI_STEP : step_r;

  always_comb begin
    out_byte_nxt   = 8'h00;
    byte_valid_nxt = 1'b1;
    out_last_nxt   = q_head.last;
    status_nxt     = ST_OK;
    done           = 1'b1;
    case (q_head.kind)
      JOB_ENC: begin
        done         = (eff_step == ENC_LAST_STEP);
        out_last_nxt = q_head.last && done;
        if (eff_step == ENC_LAST_STEP) begin
          out_byte_nxt = nibble_to_hex(q_head.value[3:0]);
        end else if (eff_step == ENC_HI_STEP) begin
          out_byte_nxt = nibble_to_hex(q_head.value[7:4]);
        end else begin
          out_byte_nxt = prefix_char(eff_step[1:0]);
        end
      end
      JOB_DATA: begin
        out_byte_nxt = q_head.value;
      end
      JOB_STATUS: begin
        byte_valid_nxt = 1'b0;
        out_last_nxt   = 1'b1;
        status_nxt     = q_head.status;
      end
      default: begin
        byte_valid_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = done ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 3'd0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r   <= out_byte_nxt;
      byte_valid_r <= byte_valid_nxt;
      out_last_r   <= out_last_nxt;
      status_r     <= status_nxt;
    end
  end

  a_status_only_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !byte_valid_r) |-> out_last_r)
    else $error("status-only word not marked last");
  a_error_only_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |-> !byte_valid_r)
    else $error("error status on a data word");
  a_step_idle_reset: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> step_r == 3'd0)
    else $error("step counter left mid-job with empty queue");

endmodule
